### rtl/btint_pkg.sv
`default_nettype none

package btint_pkg;

    // Fixed field widths
    localparam int TIME_W     = 32;
    localparam int VALUE_W    = 32;
    localparam int INDEX_W    = 6;
    localparam int FRAC_W     = 16;
    localparam int COUNT_W    = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // Horner accumulator and product widths
    localparam int ACC_W  = 40;
    localparam int PROD_W = ACC_W + FRAC_W + 1;

    // Fraction divider: one quotient bit per cycle
    localparam int DIV_STEPS = FRAC_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int DEF_MAX_POINTS = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 1'd1;

    // Transaction kinds
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_PICK,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_RD_D,
        ST_RD_E,
        ST_DIV_INIT,
        ST_DIV,
        ST_LOAD,
        ST_MUL,
        ST_ACC,
        ST_END_RD,
        ST_FIN
    } state_t;

    typedef enum logic [2:0] {
        CAP_NONE,
        CAP_T0Y0,
        CAP_T1Y1,
        CAP_Y2,
        CAP_Y3,
        CAP_YEND
    } cap_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_LOAD,
        OP_MUL,
        OP_ACC,
        OP_FIN
    } op_t;

    typedef enum logic [1:0] {
        COEF_C2,
        COEF_C1,
        COEF_C0,
        COEF_Y1
    } coef_t;

    typedef enum logic [1:0] {
        FIN_EMPTY,
        FIN_END,
        FIN_INTERP
    } fin_t;

    typedef struct packed {
        logic  wr;
        logic  ld_time;
        logic  cubic;
        cap_t  cap;
        op_t   op;
        coef_t coef;
        fin_t  fin;
    } btint_cmd_t;

    typedef struct packed {
        logic t_le_time;
        logic time_le_t;
        logic out_free;
    } btint_sts_t;

endpackage

`default_nettype wire

### rtl/breakpoint_table_interpolator.sv
// Breakpoint table interpolator. Write transactions (kind 0) store one
// (time, value) breakpoint; sample transactions (kind 1) return one
// interpolated Q16.16 value, linear or Catmull-Rom cubic as set by the
// mode register (cubic needs at least four points), over the first
// point_count entries. A sample runs a linear scan of the time memory (one
// entry per cycle, set by its single read port), operand reads, a
// restoring divider for the blend fraction, and a shared multiplier
// stepping the Horner evaluation. Items are handled one at a time; the
// next one is taken while a finished result still waits in the output
// register. Samples at or outside the table ends skip the divider; an
// empty table skips the scan. The user must write configuration only while
// the block is idle; the block itself does not enforce this. Reading an
// entry that was never written gives an undefined value.
`default_nettype none

module breakpoint_table_interpolator
    import btint_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       kind,
    input  wire logic [INDEX_W-1:0]         point_index,
    input  wire logic [TIME_W-1:0]          point_time,
    input  wire logic signed [VALUE_W-1:0]  point_value,
    input  wire logic [TIME_W-1:0]          sample_time,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [VALUE_W-1:0]       sample_value,
    output logic                            saturated,
    output logic                            empty_table
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    btint_cmd_t    cmd;
    btint_sts_t    sts;
    logic [AW-1:0] t_addr, v_addr;

    btint_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .sts       (sts),
        .cmd       (cmd),
        .t_addr    (t_addr),
        .v_addr    (v_addr)
    );

    btint_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .t_addr       (t_addr),
        .v_addr       (v_addr),
        .sts          (sts),
        .point_index  (point_index),
        .point_time   (point_time),
        .point_value  (point_value),
        .sample_time  (sample_time),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sample_value (sample_value),
        .saturated    (saturated),
        .empty_table  (empty_table)
    );

endmodule

`default_nettype wire

### rtl/btint_dp.sv
`default_nettype none

module btint_dp
    import btint_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire btint_cmd_t                 cmd,
    input  wire logic [AW-1:0]              t_addr,
    input  wire logic [AW-1:0]              v_addr,
    output btint_sts_t                      sts,
    input  wire logic [INDEX_W-1:0]         point_index,
    input  wire logic [TIME_W-1:0]          point_time,
    input  wire logic signed [VALUE_W-1:0]  point_value,
    input  wire logic [TIME_W-1:0]          sample_time,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [VALUE_W-1:0]       sample_value,
    output logic                            saturated,
    output logic                            empty_table
);

    // Breakpoint memories
    logic [TIME_W-1:0]         time_mem [MAX_POINTS];
    logic signed [VALUE_W-1:0] value_mem [MAX_POINTS];
    logic [TIME_W-1:0]         rd_t_reg;
    logic signed [VALUE_W-1:0] rd_v_reg;
    logic                      wr_ok;

    assign wr_ok = (32'(point_index) < MAX_POINTS);

    always_ff @(posedge clk)
    begin
        if (cmd.wr && wr_ok)
        begin
            time_mem[AW'(point_index)]  <= point_time;
            value_mem[AW'(point_index)] <= point_value;
        end
        rd_t_reg <= time_mem[t_addr];
        rd_v_reg <= value_mem[v_addr];
    end

    // Operand registers
    logic [TIME_W-1:0]         time_reg, t0_reg, t1_reg;
    logic signed [VALUE_W-1:0] y0_reg, y1_reg, y2_reg, y3_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.ld_time)
        begin
            time_reg <= sample_time;
        end
        unique case (cmd.cap)
            CAP_T0Y0:
            begin
                t0_reg <= rd_t_reg;
                y0_reg <= rd_v_reg;
            end
            CAP_T1Y1:
            begin
                t1_reg <= rd_t_reg;
                y1_reg <= rd_v_reg;
            end
            CAP_Y2:   y2_reg <= rd_v_reg;
            CAP_Y3:   y3_reg <= rd_v_reg;
            default:  ;
        endcase
    end

    assign sts.t_le_time = (rd_t_reg <= time_reg);
    assign sts.time_le_t = (time_reg <= rd_t_reg);
    assign sts.out_free  = !out_valid || out_ready;

    // Fraction divider, restoring, one bit per step
    logic [TIME_W-1:0] num, den, rem_reg, den_reg;
    logic [TIME_W:0]   rem_sh;
    logic [FRAC_W-1:0] q_reg;
    logic              div_act_reg;

    assign num    = time_reg - t0_reg;
    assign den    = t1_reg - t0_reg;
    assign rem_sh = {rem_reg, 1'b0};

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_DIV_INIT)
        begin
            den_reg <= den;
            rem_reg <= num;
            if (t1_reg <= t0_reg)
            begin
                q_reg       <= '0;
                div_act_reg <= 1'b0;
            end
            else if (num >= den)
            begin
                q_reg       <= '1;
                div_act_reg <= 1'b0;
            end
            else
            begin
                q_reg       <= '0;
                div_act_reg <= 1'b1;
            end
        end
        else if (cmd.op == OP_DIV_STEP && div_act_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_reg <= TIME_W'(rem_sh - {1'b0, den_reg});
                q_reg   <= {q_reg[FRAC_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[TIME_W-1:0];
                q_reg   <= {q_reg[FRAC_W-2:0], 1'b0};
            end
        end
    end

    // Catmull-Rom coefficients, exact
    logic signed [ACC_W-1:0] e0, e1, e2, e3, c0, c1, c2, c3, dlin, coef;

    assign e0   = ACC_W'(y0_reg);
    assign e1   = ACC_W'(y1_reg);
    assign e2   = ACC_W'(y2_reg);
    assign e3   = ACC_W'(y3_reg);
    assign c3   = -e0 + 3 * e1 - 3 * e2 + e3;
    assign c2   = 2 * e0 - 5 * e1 + 4 * e2 - e3;
    assign c1   = e2 - e0;
    assign c0   = 2 * e1;
    assign dlin = e2 - e1;

    always_comb
    begin
        unique case (cmd.coef)
            COEF_C2: coef = c2;
            COEF_C1: coef = c1;
            COEF_C0: coef = c0;
            COEF_Y1: coef = e1;
            default: coef = e1;
        endcase
    end

    // Horner step: h <= coef + round(a * h / 2^16)
    logic signed [ACC_W-1:0]  h_reg;
    logic signed [PROD_W-1:0] prod_reg, rsum, rsh;

    assign rsum = prod_reg + $signed(PROD_W'(32768));
    assign rsh  = rsum >>> FRAC_W;

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD: h_reg    <= cmd.cubic ? c3 : dlin;
            OP_MUL:  prod_reg <= $signed({1'b0, q_reg}) * h_reg;
            OP_ACC:  h_reg    <= coef + $signed(rsh[ACC_W-1:0]);
            default: ;
        endcase
    end

    // Final halving (cubic only) and saturation
    logic signed [ACC_W-1:0] hp1, fin_v;
    logic                    sat_hi, sat_lo;

    assign hp1    = h_reg + $signed(ACC_W'(1));
    assign fin_v  = cmd.cubic ? (hp1 >>> 1) : h_reg;
    assign sat_hi = fin_v > $signed(ACC_W'(32'h7fff_ffff));
    assign sat_lo = fin_v < $signed({{(ACC_W-VALUE_W){1'b1}}, 32'h8000_0000});

    // Output register
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_FIN)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_FIN)
        begin
            unique case (cmd.fin)
                FIN_EMPTY:
                begin
                    sample_value <= '0;
                    saturated    <= 1'b0;
                    empty_table  <= 1'b1;
                end
                FIN_END:
                begin
                    // end value sits in the read register, address held
                    sample_value <= rd_v_reg;
                    saturated    <= 1'b0;
                    empty_table  <= 1'b0;
                end
                default:
                begin
                    if (sat_hi)
                    begin
                        sample_value <= 32'sh7fff_ffff;
                    end
                    else if (sat_lo)
                    begin
                        sample_value <= 32'sh8000_0000;
                    end
                    else
                    begin
                        sample_value <= fin_v[VALUE_W-1:0];
                    end
                    saturated   <= sat_hi || sat_lo;
                    empty_table <= 1'b0;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

### rtl/btint_ctrl.sv
`default_nettype none

module btint_ctrl
    import btint_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
    localparam int CW = $clog2(MAX_POINTS + 1)
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  kind,
    input  wire btint_sts_t            sts,
    output btint_cmd_t                 cmd,
    output logic [AW-1:0]              t_addr,
    output logic [AW-1:0]              v_addr
);

    // Configuration registers
    logic               mode_reg;
    logic [COUNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODE:  mode_reg  <= cfg_data[0];
                CFG_COUNT: count_reg <= cfg_data[COUNT_W-1:0];
                default:   ;
            endcase
        end
    end

    // Control state
    state_t               state_reg, state_next;
    logic [CW-1:0]        n_reg, n_next;
    logic [AW-1:0]        j_reg, j_next, jd_reg, jd_next, i_reg, i_next;
    logic [AW-1:0]        end_reg, end_next;
    logic                 rdv_reg, rdv_next, lo_reg, lo_next, hi_reg, hi_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]           k_reg, k_next;
    fin_t                 fin_reg, fin_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            j_reg     <= '0;
            jd_reg    <= '0;
            i_reg     <= '0;
            end_reg   <= '0;
            rdv_reg   <= 1'b0;
            lo_reg    <= 1'b0;
            hi_reg    <= 1'b0;
            cnt_reg   <= '0;
            k_reg     <= '0;
            fin_reg   <= FIN_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            j_reg     <= j_next;
            jd_reg    <= jd_next;
            i_reg     <= i_next;
            end_reg   <= end_next;
            rdv_reg   <= rdv_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            fin_reg   <= fin_next;
        end
    end

    // Neighbor indices, clamped
    logic [AW-1:0] nm1, ip1, i0, i3;
    logic          cubic;

    assign nm1   = AW'(n_reg - CW'(1));
    assign ip1   = AW'(32'(i_reg) + 1);
    assign i0    = (i_reg != '0) ? AW'(32'(i_reg) - 1) : '0;
    assign i3    = (32'(i_reg) + 2 < 32'(n_reg) - 1) ? AW'(32'(i_reg) + 2) : nm1;
    assign cubic = mode_reg && (32'(n_reg) >= 4);

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        j_next      = j_reg;
        jd_next     = jd_reg;
        i_next      = i_reg;
        end_next    = end_reg;
        rdv_next    = 1'b0;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        cnt_next    = cnt_reg;
        k_next      = k_reg;
        fin_next    = fin_reg;
        in_ready    = 1'b0;
        t_addr      = j_reg;
        v_addr      = end_reg;
        cmd.wr      = 1'b0;
        cmd.ld_time = 1'b0;
        cmd.cubic   = cubic;
        cmd.cap     = CAP_NONE;
        cmd.op      = OP_NONE;
        cmd.coef    = COEF_Y1;
        cmd.fin     = fin_reg;

        // Search bookkeeping for the entry read last cycle
        if (rdv_reg)
        begin
            if (jd_reg == '0)
            begin
                lo_next = sts.time_le_t;
            end
            if (jd_reg == nm1)
            begin
                hi_next = sts.t_le_time;
            end
            if (jd_reg != '0 && jd_reg != nm1 && sts.t_le_time)
            begin
                i_next = jd_reg;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (kind == KIND_WRITE)
                    begin
                        cmd.wr = 1'b1;
                    end
                    else
                    begin
                        cmd.ld_time = 1'b1;
                        n_next = (32'(count_reg) > MAX_POINTS) ? CW'(MAX_POINTS)
                                                               : CW'(count_reg);
                        j_next = '0;
                        i_next = '0;
                        k_next = '0;
                        if (count_reg == '0)
                        begin
                            fin_next   = FIN_EMPTY;
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                t_addr   = j_reg;
                jd_next  = j_reg;
                rdv_next = 1'b1;
                j_next   = AW'(32'(j_reg) + 1);
                if (j_reg == nm1)
                begin
                    state_next = ST_SCAN_LAST;
                end
            end
            ST_SCAN_LAST:
            begin
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                if (n_reg == CW'(1) || lo_reg)
                begin
                    end_next   = '0;
                    state_next = ST_END_RD;
                end
                else if (hi_reg)
                begin
                    end_next   = nm1;
                    state_next = ST_END_RD;
                end
                else
                begin
                    state_next = ST_RD_A;
                end
            end
            ST_RD_A:
            begin
                t_addr     = i_reg;
                v_addr     = i0;
                state_next = ST_RD_B;
            end
            ST_RD_B:
            begin
                t_addr     = ip1;
                v_addr     = i_reg;
                cmd.cap    = CAP_T0Y0;
                state_next = ST_RD_C;
            end
            ST_RD_C:
            begin
                v_addr     = ip1;
                cmd.cap    = CAP_T1Y1;
                state_next = ST_RD_D;
            end
            ST_RD_D:
            begin
                v_addr     = i3;
                cmd.cap    = CAP_Y2;
                state_next = ST_RD_E;
            end
            ST_RD_E:
            begin
                cmd.cap    = CAP_Y3;
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                cmd.op     = OP_DIV_INIT;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = DIV_CNT_W'(32'(cnt_reg) + 1);
                if (32'(cnt_reg) == DIV_STEPS - 1)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.op     = OP_LOAD;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.op     = OP_MUL;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.op = OP_ACC;
                if (!cubic)
                begin
                    cmd.coef = COEF_Y1;
                end
                else if (k_reg == 2'd0)
                begin
                    cmd.coef = COEF_C2;
                end
                else if (k_reg == 2'd1)
                begin
                    cmd.coef = COEF_C1;
                end
                else
                begin
                    cmd.coef = COEF_C0;
                end
                if (!cubic || k_reg == 2'd2)
                begin
                    fin_next   = FIN_INTERP;
                    state_next = ST_FIN;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            ST_END_RD:
            begin
                v_addr     = end_reg;
                fin_next   = FIN_END;
                state_next = ST_FIN;
                // value lands in the read register for ST_FIN, address held
            end
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_FIN;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Interval picked for blending always has a right neighbor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_A) |-> (32'(i_reg) + 2 <= 32'(n_reg)))
        else $error("interval index beyond table");

    // Empty result only for an empty table
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_FIN && fin_reg == FIN_EMPTY) |-> (n_reg == '0 || count_reg == '0))
        else $error("empty flag with points in use");

    // Result is only loaded when the output register can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_FIN) |-> sts.out_free)
        else $error("result overwrites pending output");

    // Horner load only follows the divider state
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> ($past(state_reg) == ST_DIV))
        else $error("load without completed division");

endmodule

`default_nettype wire
